FILE: src/iplpm_pkg.sv
// Shared types, constants and helpers for the IPv4 longest-prefix-match table.
// Used by the controller, the datapath and the top level. No dependencies.
`default_nettype none

package iplpm_pkg;

    localparam int ADDR_W  = 32;
    localparam int LEN_W   = 6;
    localparam int TAG_W   = 16;
    localparam int RES_W   = 1 + 1 + TAG_W + LEN_W;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int TAG_BITS_DEF      = 16;

    localparam logic [LEN_W-1:0] MAX_LEN = 6'd32;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_SEARCH = 1'b1
    } t_op;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // Controller -> datapath
    typedef struct packed {
        logic start;   // latch a new item, restart the scan
        logic rd_en;   // read the entry under the scan pointer
        logic finish;  // commit insert, load the result register
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic rd_done;   // every filled entry has been read
        logic cmp_busy;  // a read word is still being compared
        logic out_free;  // result register can take a new beat
    } t_dp_sts;

    // Mask with the top len bits set; len is at most 32.
    function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
        logic [ADDR_W-1:0] m;
        if (len == '0) begin
            m = '0;
        end else begin
            m = {ADDR_W{1'b1}} << (MAX_LEN - len);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

FILE: src/iplpm_ctrl.sv
// Sequencer for the prefix table: accept, scan, commit, back to idle.
// Depends on iplpm_pkg for the command and status structs.
`default_nettype none

module iplpm_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_s_valid,
    output logic                o_s_ready,
    input  iplpm_pkg::t_dp_sts  i_sts,
    output iplpm_pkg::t_dp_cmd  o_cmd
);
    import iplpm_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_valid) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                // wait for the last compare to drain
                if (i_sts.rd_done && !i_sts.cmp_busy) n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // hold off the input while reset is asserted
    assign o_s_ready    = i_rst_n && (r_state == ST_IDLE);
    assign o_cmd.start  = i_rst_n && (r_state == ST_IDLE) && i_s_valid;
    assign o_cmd.rd_en  = (r_state == ST_SCAN) && !i_sts.rd_done;
    assign o_cmd.finish = (r_state == ST_FINISH) && i_sts.out_free;

endmodule

`default_nettype wire

FILE: src/iplpm_dp.sv
// Datapath: prefix memory, scan pointer, compare stage, best-match tracking
// and the result register. Depends on iplpm_pkg.
`default_nettype none

module iplpm_dp #(
    parameter int TABLE_ENTRIES = iplpm_pkg::TABLE_ENTRIES_DEF,
    parameter int TAG_BITS      = iplpm_pkg::TAG_BITS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  iplpm_pkg::t_dp_cmd                i_cmd,
    output iplpm_pkg::t_dp_sts                o_sts,
    input  wire                               i_op,
    input  wire  [iplpm_pkg::ADDR_W-1:0]      i_address,
    input  wire  [iplpm_pkg::LEN_W-1:0]       i_prefix_length,
    input  wire  [iplpm_pkg::TAG_W-1:0]       i_route_tag,
    output logic                              o_res_valid,
    input  wire                               i_res_ready,
    output logic [iplpm_pkg::RES_W-1:0]       o_res_data
);
    import iplpm_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int ENT_W = ADDR_W + LEN_W + TAG_BITS;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

    // entry layout: {prefix, length, tag}
    logic [ENT_W-1:0]    r_mem [TABLE_ENTRIES];

    t_op                 r_op;
    logic [ADDR_W-1:0]   r_addr;
    logic [ADDR_W-1:0]   r_base;
    logic [LEN_W-1:0]    r_len;
    logic [TAG_BITS-1:0] r_tag;

    logic [CNT_W-1:0]    r_used;
    logic [CNT_W-1:0]    r_rd_cnt;
    logic [ENT_W-1:0]    r_rd_data;
    logic [IDX_W-1:0]    r_cmp_idx;
    logic                r_cmp_vld;

    logic                r_hit;
    logic [IDX_W-1:0]    r_hit_idx;
    logic                r_best_vld;
    logic [LEN_W-1:0]    r_best_len;
    logic [TAG_BITS-1:0] r_best_tag;

    logic                r_out_vld;
    logic [RES_W-1:0]    r_out_data;

    logic [LEN_W-1:0]    in_len_sat;
    logic [ADDR_W-1:0]   e_prefix;
    logic [LEN_W-1:0]    e_len;
    logic [TAG_BITS-1:0] e_tag;
    logic                ins_match;
    logic                srch_match;
    logic                better;
    logic                full;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_idx;
    logic                res_status;
    logic                res_matched;
    logic [TAG_W-1:0]    res_tag;
    logic [LEN_W-1:0]    res_len;

    assign in_len_sat = (i_prefix_length > MAX_LEN) ? MAX_LEN : i_prefix_length;

    assign e_prefix = r_rd_data[ENT_W-1 -: ADDR_W];
    assign e_len    = r_rd_data[TAG_BITS +: LEN_W];
    assign e_tag    = r_rd_data[TAG_BITS-1:0];

    assign ins_match  = (e_len == r_len) && (e_prefix == r_base);
    assign srch_match = ((r_addr & len_mask(e_len)) == e_prefix);
    // strict compare keeps the earliest slot among equal lengths
    assign better     = srch_match && (!r_best_vld || (e_len > r_best_len));

    assign full   = (r_used == FULL_CNT);
    assign wr_idx = r_hit ? r_hit_idx : r_used[IDX_W-1:0];
    assign wr_en  = i_cmd.finish && (r_op == OP_INSERT) && (r_hit || !full);

    // Item registers and scan pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op   <= t_op'(i_op);
            r_addr <= i_address;
            r_base <= i_address & len_mask(in_len_sat);
            r_len  <= in_len_sat;
            r_tag  <= TAG_BITS'(i_route_tag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_cnt  <= '0;
            r_cmp_vld <= 1'b0;
            r_used    <= '0;
        end else begin
            if (i_cmd.start) begin
                r_rd_cnt <= '0;
            end else if (i_cmd.rd_en) begin
                r_rd_cnt <= r_rd_cnt + 1'b1;
            end
            r_cmp_vld <= i_cmd.rd_en;
            if (wr_en && !r_hit) begin
                r_used <= r_used + 1'b1;
            end
        end
    end

    // Single-port table: reads during the scan, one write at commit
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_idx] <= {r_base, r_len, r_tag};
        end else if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[r_rd_cnt[IDX_W-1:0]];
        end
        if (i_cmd.rd_en) begin
            r_cmp_idx <= r_rd_cnt[IDX_W-1:0];
        end
    end

    // Compare stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit      <= 1'b0;
            r_best_vld <= 1'b0;
        end else if (i_cmd.start) begin
            r_hit      <= 1'b0;
            r_best_vld <= 1'b0;
        end else if (r_cmp_vld) begin
            if (ins_match) begin
                r_hit <= 1'b1;
            end
            if (better) begin
                r_best_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_cmp_vld && ins_match) begin
            r_hit_idx <= r_cmp_idx;
        end
        if (r_cmp_vld && better) begin
            r_best_len <= e_len;
            r_best_tag <= e_tag;
        end
    end

    // Result assembly
    always_comb begin
        res_status  = STATUS_OK;
        res_matched = 1'b0;
        res_tag     = '0;
        res_len     = '0;
        unique case (r_op)
            OP_INSERT: begin
                if (!r_hit && full) res_status = STATUS_FULL;
            end
            OP_SEARCH: begin
                if (r_best_vld) begin
                    res_matched = 1'b1;
                    res_tag     = TAG_W'(r_best_tag);
                    res_len     = r_best_len;
                end
            end
            default: res_status = STATUS_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_vld <= 1'b1;
        end else if (i_res_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_data <= {res_len, res_tag, res_matched, res_status};
        end
    end

    assign o_sts.rd_done  = (r_rd_cnt == r_used);
    assign o_sts.cmp_busy = r_cmp_vld;
    assign o_sts.out_free = !r_out_vld || i_res_ready;

    assign o_res_valid = r_out_vld;
    assign o_res_data  = r_out_data;

endmodule

`default_nettype wire

FILE: src/ipv4_longest_prefix_match.sv
// Channel  Dir  Beat contents (low bit first)
// -------  ---  --------------------------------------------------------------
// s_axis   in   tdata: address[31:0], prefix_length[37:32], route_tag[53:38],
//               zero[55:54]; tuser: op[0] (0 insert, 1 search)
// m_axis   out  tdata: status[0], matched[1], match_tag[17:2], match_length[23:18]
//
// An item is accepted, every filled slot is read and compared, and the result is
// committed before the next item is accepted; the scan grows with the used slots.
// The single-port prefix memory is read once per cycle during the scan and written
// once at commit. Reset (i_rst_n low, synchronous) empties the table; no clearing
// pass is needed, and s_axis_tready stays low while reset is held.
// A result beat waits in its own register; a stalled m_axis holds only the commit.
// Top level; depends on iplpm_pkg, iplpm_ctrl and iplpm_dp.
`default_nettype none

module ipv4_longest_prefix_match #(
    parameter int TABLE_ENTRIES = iplpm_pkg::TABLE_ENTRIES_DEF,
    parameter int TAG_BITS      = iplpm_pkg::TAG_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [55:0] s_axis_tdata,   // address, prefix_length, route_tag, pad
    input  wire  [0:0]  s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [23:0] m_axis_tdata    // status, matched, match_tag, match_length
);
    import iplpm_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    iplpm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    iplpm_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .TAG_BITS      (TAG_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_op            (s_axis_tuser[0]),
        .i_address       (s_axis_tdata[ADDR_W-1:0]),
        .i_prefix_length (s_axis_tdata[ADDR_W +: LEN_W]),
        .i_route_tag     (s_axis_tdata[ADDR_W+LEN_W +: TAG_W]),
        .o_res_valid     (m_axis_tvalid),
        .i_res_ready     (m_axis_tready),
        .o_res_data      (m_axis_tdata)
    );

endmodule

`default_nettype wire

FILE: src/iplpm_checker.sv
// Port-level checks for the prefix table, bound to the top level.
// Depends only on the ports of ipv4_longest_prefix_match.
`default_nettype none

module iplpm_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [23:0] m_axis_tdata
);

    // one item in flight: no back-to-back accepts
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while an item is in flight");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result beat changed while stalled");

    // a refused insert never reports a match
    a_full_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[23:1] == '0))
        else $error("refused insert carries match fields");

    // no match means zero tag and length; a length never exceeds 32
    a_no_match_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[1] || (m_axis_tdata[23:2] == '0))
                           && (m_axis_tdata[23:18] <= 6'd32)))
        else $error("bad match fields in result beat");

endmodule

bind ipv4_longest_prefix_match iplpm_checker u_iplpm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
